// ----- rtl/mfbr_pkg.sv -----
`timescale 1ns / 1ps

package mfbr_pkg;

   localparam int DEPTH_DEFAULT = 512;
   localparam int MARKER_W = 24;
   localparam int LEN_W = 9;
   localparam int LEN_MAX = 511;
   localparam int CSR_IDX_W = 1;
   localparam logic [MARKER_W-1:0] START_RESET = 24'hAABBCC;
   localparam logic [MARKER_W-1:0] END_RESET = 24'hDDEEFF;
   localparam logic [1:0] MARKER_LAST = 2'd2;

   typedef enum logic [1:0] {
      ACT_BYTE = 2'd0,
      ACT_READ = 2'd1,
      ACT_TAKE = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START = 1'b0,
      CSR_END   = 1'b1
   } csr_index_type;

   function automatic logic marker_hit(input logic [MARKER_W-1:0] marker,
                                       input logic [1:0] idx,
                                       input logic [7:0] rx);
      logic hit;
      hit = 1'b0;
      case (idx)
         2'd0: hit = (rx == marker[23:16]);
         2'd1: hit = (rx == marker[15:8]);
         2'd2: hit = (rx == marker[7:0]);
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

// ----- rtl/marker_framed_byte_receiver_top.sv -----
`timescale 1ns / 1ps

// stages: two register stages, p_ and o_; a result is registered in p_ when its
//   transaction is accepted, then in o_ as it advances
// throughput: one transaction per cycle while req_stall is low, set by the
//   single write port and the registered read port of the payload memory
// reset: synchronous, clears framing state, ready flag, length and pipeline,
//   markers return to their defaults; payload memory is not cleared
module marker_framed_byte_receiver_top #(
   parameter int BUFFER_DEPTH = mfbr_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_action,
   input  logic [7:0]                     req_rx_byte,
   input  logic [8:0]                     req_read_index,
   input  logic [9:0]                     req_max_length,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mfbr_pkg::LEN_W-1:0]     rsp_message_length,
   output logic [7:0]                     rsp_read_data,
   output logic                           rsp_frame_ready,
   output logic                           rsp_taken,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mfbr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mfbr_pkg::MARKER_W-1:0]  csr_data
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int PW = $clog2(BUFFER_DEPTH + 1);
   localparam int LW = (PW > 10) ? PW : 10;
   localparam int IW = ((AW > 9) ? AW : 9) + 1;

   logic [7:0] mem [BUFFER_DEPTH];

   logic                          receiving_ff, receiving_in;
   logic [1:0]                    match_ff, match_in;
   logic [PW-1:0]                 wpos_ff, wpos_in;
   logic                          ready_ff, ready_in;
   logic [mfbr_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [mfbr_pkg::MARKER_W-1:0] start_ff, end_ff;

   logic                          p_valid_ff, p_valid_in;
   logic [mfbr_pkg::LEN_W-1:0]    p_msg_ff;
   logic                          p_ready_ff, p_taken_ff, p_read_ff;
   logic [7:0]                    mem_rd_ff;

   logic                          o_valid_ff, o_valid_in;
   logic [mfbr_pkg::LEN_W-1:0]    o_msg_ff;
   logic [7:0]                    o_rdata_ff;
   logic                          o_ready_ff, o_taken_ff;

   logic                          accept, p_adv, mem_we, taken, is_read, full;
   logic                          hit_start, hit_end;
   mfbr_pkg::action_type          act;
   logic [IW-1:0]                 idx_ext;
   logic [LW-1:0]                 frame_len;
   logic [mfbr_pkg::LEN_W-1:0]    sat_len, msg;

   assign csr_ready = 1'b1;
   assign p_adv     = p_valid_ff && (!o_valid_ff || !rsp_stall);
   assign req_stall = p_valid_ff && o_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign act       = mfbr_pkg::action_type'(req_action);
   assign idx_ext   = IW'(req_read_index);
   assign is_read   = (act == mfbr_pkg::ACT_READ) && (idx_ext < IW'(BUFFER_DEPTH));
   assign full      = (wpos_ff >= PW'(BUFFER_DEPTH));
   assign hit_start = mfbr_pkg::marker_hit(start_ff, match_ff, req_rx_byte);
   assign hit_end   = mfbr_pkg::marker_hit(end_ff, match_ff, req_rx_byte);
   assign frame_len = LW'(wpos_ff) - LW'(2);
   assign sat_len   = (frame_len > LW'(mfbr_pkg::LEN_MAX)) ?
                      mfbr_pkg::LEN_W'(mfbr_pkg::LEN_MAX) : frame_len[mfbr_pkg::LEN_W-1:0];

   always_comb begin
      receiving_in = receiving_ff;
      match_in     = match_ff;
      wpos_in      = wpos_ff;
      ready_in     = ready_ff;
      len_in       = len_ff;
      mem_we       = 1'b0;
      taken        = 1'b0;
      if (accept) begin
         unique case (act)
            mfbr_pkg::ACT_BYTE: begin
               if (!receiving_ff) begin
                  if (hit_start) begin
                     if (match_ff == mfbr_pkg::MARKER_LAST) begin
                        receiving_in = 1'b1;
                        match_in     = '0;
                        wpos_in      = '0;
                     end else begin
                        match_in = match_ff + 2'd1;
                     end
                  end else begin
                     match_in = '0;
                  end
               end else if (full) begin
                  receiving_in = 1'b0;
                  match_in     = '0;
                  wpos_in      = '0;
               end else begin
                  mem_we  = 1'b1;
                  wpos_in = wpos_ff + PW'(1);
                  if (hit_end) begin
                     if (match_ff == mfbr_pkg::MARKER_LAST) begin
                        ready_in     = 1'b1;
                        len_in       = sat_len;
                        receiving_in = 1'b0;
                        match_in     = '0;
                        wpos_in      = '0;
                     end else begin
                        match_in = match_ff + 2'd1;
                     end
                  end else begin
                     match_in = '0;
                  end
               end
            end
            mfbr_pkg::ACT_TAKE: begin
               if (ready_ff && (len_ff != '0) && ({1'b0, len_ff} <= req_max_length)) begin
                  ready_in = 1'b0;
                  taken    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (act == mfbr_pkg::ACT_TAKE) begin
         msg = ready_ff ? len_ff : '0;
      end else begin
         msg = ready_in ? len_in : '0;
      end
      p_valid_in = accept ? 1'b1 : (p_valid_ff && !p_adv);
      o_valid_in = p_adv ? 1'b1 : (o_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         match_ff     <= '0;
         wpos_ff      <= '0;
         ready_ff     <= 1'b0;
         len_ff       <= '0;
         start_ff     <= mfbr_pkg::START_RESET;
         end_ff       <= mfbr_pkg::END_RESET;
         p_valid_ff   <= 1'b0;
         o_valid_ff   <= 1'b0;
      end else begin
         receiving_ff <= receiving_in;
         match_ff     <= match_in;
         wpos_ff      <= wpos_in;
         ready_ff     <= ready_in;
         len_ff       <= len_in;
         p_valid_ff   <= p_valid_in;
         o_valid_ff   <= o_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (mfbr_pkg::csr_index_type'(csr_index))
               mfbr_pkg::CSR_START: start_ff <= csr_data;
               mfbr_pkg::CSR_END:   end_ff   <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wpos_ff[AW-1:0]] <= req_rx_byte;
      end
      if (accept && is_read) begin
         mem_rd_ff <= mem[idx_ext[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_msg_ff   <= msg;
         p_ready_ff <= ready_in;
         p_taken_ff <= taken;
         p_read_ff  <= is_read;
      end
      if (p_adv) begin
         o_msg_ff   <= p_msg_ff;
         o_rdata_ff <= p_read_ff ? mem_rd_ff : 8'd0;
         o_ready_ff <= p_ready_ff;
         o_taken_ff <= p_taken_ff;
      end
   end

   assign rsp_valid          = o_valid_ff;
   assign rsp_message_length = o_msg_ff;
   assign rsp_read_data      = o_rdata_ff;
   assign rsp_frame_ready    = o_ready_ff;
   assign rsp_taken          = o_taken_ff;

endmodule

// ----- rtl/mfbr_checker.sv -----
`timescale 1ns / 1ps

module mfbr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [mfbr_pkg::LEN_W-1:0]     rsp_message_length,
   input logic [7:0]                     rsp_read_data,
   input logic                           rsp_frame_ready,
   input logic                           rsp_taken
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a successful take never reports an empty message
   a_take_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_taken) |-> (rsp_message_length != '0))
      else $error("take with zero length");

   // a successful take leaves nothing ready
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_taken) |-> !rsp_frame_ready)
      else $error("ready still set after take");

   // length is zero while nothing is ready, unless the transaction took it
   a_len_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_ready && !rsp_taken) |-> (rsp_message_length == '0))
      else $error("length reported with no message ready");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_message_length)
                                    && $stable(rsp_read_data)))
      else $error("stalled result changed");

endmodule

bind marker_framed_byte_receiver_top mfbr_checker u_mfbr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_message_length (rsp_message_length),
   .rsp_read_data      (rsp_read_data),
   .rsp_frame_ready    (rsp_frame_ready),
   .rsp_taken          (rsp_taken)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [8:0] msg_len;
      logic [7:0] rdata;
      logic       rdy;
      logic       tkn;
   } frame_status_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [1:0]                     req_action = mfbr_pkg::ACT_BYTE;
   logic [7:0]                     req_rx_byte = '0;
   logic [8:0]                     req_read_index = '0;
   logic [9:0]                     req_max_length = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [mfbr_pkg::LEN_W-1:0]     rsp_message_length;
   logic [7:0]                     rsp_read_data;
   logic                           rsp_frame_ready;
   logic                           rsp_taken;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [mfbr_pkg::CSR_IDX_W-1:0] csr_index = mfbr_pkg::CSR_START;
   logic [mfbr_pkg::MARKER_W-1:0]  csr_data = '0;

   // predictor state
   logic [23:0]   start_mk = mfbr_pkg::START_RESET;
   logic [23:0]   end_mk = mfbr_pkg::END_RESET;
   logic          in_frame = 1'b0;
   logic [1:0]    match_idx = '0;
   int unsigned   wr_pos = 0;
   int unsigned   store_fill = 0;
   logic [7:0]    store [mfbr_pkg::DEPTH_DEFAULT];
   logic          ready = 1'b0;
   logic [8:0]    frame_len = '0;

   frame_status_type expected_status_q[$];
   frame_status_type rsp_head;
   int unsigned   mismatch_count = 0;
   int unsigned   items_sent = 0;
   int unsigned   send_idle_pct = 13;
   int unsigned   recv_idle_pct = 82;

   marker_framed_byte_receiver_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_rx_byte        (req_rx_byte),
      .req_read_index     (req_read_index),
      .req_max_length     (req_max_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_message_length (rsp_message_length),
      .rsp_read_data      (rsp_read_data),
      .rsp_frame_ready    (rsp_frame_ready),
      .rsp_taken          (rsp_taken),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [7:0] marker_byte(input logic [23:0] mk, input logic [1:0] pos);
      return 8'(mk >> (8 * (2 - int'(pos))));
   endfunction

   function automatic void predict_frame_status(input logic [1:0] act, input logic [7:0] rx,
                                                input logic [8:0] idx,
                                                input logic [9:0] max_len);
      frame_status_type r;
      logic [9:0]       lim;
      r = '0;
      lim = (max_len > 10'd512) ? 10'd512 : max_len;
      if (act == mfbr_pkg::ACT_BYTE) begin
         if (!in_frame) begin
            if (rx == marker_byte(start_mk, match_idx)) begin
               if (match_idx == mfbr_pkg::MARKER_LAST) begin
                  in_frame = 1'b1;
                  match_idx = '0;
                  wr_pos = 0;
               end else begin
                  match_idx++;
               end
            end else begin
               // no second look at the first marker byte
               match_idx = '0;
            end
         end else if (wr_pos >= mfbr_pkg::DEPTH_DEFAULT) begin
            in_frame = 1'b0;
            match_idx = '0;
            wr_pos = 0;
         end else begin
            store[wr_pos] = rx;
            wr_pos++;
            if (wr_pos > store_fill) store_fill = wr_pos;
            if (rx == marker_byte(end_mk, match_idx)) begin
               if (match_idx == mfbr_pkg::MARKER_LAST) begin
                  ready = 1'b1;
                  frame_len = (wr_pos - 3 > mfbr_pkg::LEN_MAX) ?
                              9'(mfbr_pkg::LEN_MAX) : 9'(wr_pos - 3);
                  in_frame = 1'b0;
                  match_idx = '0;
                  wr_pos = 0;
               end else begin
                  match_idx++;
               end
            end else begin
               match_idx = '0;
            end
         end
      end
      r.msg_len = ready ? frame_len : '0;
      if (act == mfbr_pkg::ACT_READ) r.rdata = store[idx];
      if (act == mfbr_pkg::ACT_TAKE && ready && frame_len != 0 && lim >= 10'(frame_len)) begin
         ready = 1'b0;
         r.tkn = 1'b1;
      end
      r.rdy = ready;
      expected_status_q.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic [8:0] want,
                                       input logic [8:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status_q.size() == 0) begin
            $display("%0t: unexpected transaction, length %0d", $time, rsp_message_length);
            mismatch_count++;
         end else begin
            rsp_head = expected_status_q.pop_front();
            check_field("message_length", rsp_head.msg_len, rsp_message_length);
            check_field("read_data", 9'(rsp_head.rdata), 9'(rsp_read_data));
            check_field("frame_ready", 9'(rsp_head.rdy), 9'(rsp_frame_ready));
            check_field("taken", 9'(rsp_head.tkn), 9'(rsp_taken));
         end
      end
   end

   task automatic send_item(input logic [1:0] act, input logic [7:0] rx,
                            input logic [8:0] idx, input logic [9:0] max_len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_byte <= rx;
      req_read_index <= idx;
      req_max_length <= max_len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_frame_status(act, rx, idx, max_len);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(mfbr_pkg::ACT_BYTE, b, 9'($urandom), 10'($urandom));
   endtask

   task automatic send_take(input logic [9:0] max_len);
      send_item(mfbr_pkg::ACT_TAKE, 8'($urandom), 9'($urandom), max_len);
   endtask

   // only positions that were written at least once
   task automatic send_read();
      if (store_fill == 0)
         send_item(ACT_UNUSED, 8'($urandom), 9'($urandom), 10'($urandom));
      else
         send_item(mfbr_pkg::ACT_READ, 8'($urandom), 9'($urandom_range(0, store_fill - 1)),
                   10'($urandom));
   endtask

   task automatic send_marker(input logic [23:0] mk, input int unsigned nbytes);
      for (int i = 0; i < nbytes; i++) send_byte(mk[23 - 8 * i -: 8]);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic change_markers(input logic [23:0] s, input logic [23:0] e);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_index <= mfbr_pkg::CSR_START;
      csr_data <= s;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      start_mk = s;
      csr_index <= mfbr_pkg::CSR_END;
      csr_data <= e;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      end_mk = e;
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_frame();
      send_take(10'd0);
      send_marker(start_mk, 3);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_marker(end_mk, 3);
      send_item(mfbr_pkg::ACT_READ, 8'($urandom), 9'd0, 10'($urandom));
      send_item(mfbr_pkg::ACT_READ, 8'($urandom), 9'd1, 10'($urandom));
      send_take(10'd1);
      send_take(10'd1023);
      send_item(ACT_UNUSED, 8'($urandom), 9'($urandom), 10'($urandom));
   endtask

   task automatic test_mismatch_and_empty_frame();
      send_marker(start_mk, 2);
      send_marker(start_mk, 3);
      send_marker(start_mk, 3);
      send_marker(end_mk, 3);
      send_take(10'd512);
   endtask

   task automatic test_long_frames();
      int unsigned sizes [2] = '{509, 520};
      logic [7:0]  b;
      foreach (sizes[k]) begin
         send_marker(start_mk, 3);
         for (int i = 0; i < sizes[k]; i++) begin
            b = 8'($urandom);
            if (b == end_mk[23:16]) b = ~b;
            send_byte(b);
         end
         if (sizes[k] != 520) send_marker(end_mk, 3);
         repeat (4) send_read();
         send_item(mfbr_pkg::ACT_READ, 8'($urandom), 9'd511, 10'($urandom));
         send_take(10'(frame_len) - 10'd1);
         send_take(10'(frame_len));
      end
   endtask

   task automatic test_random_frames(input int unsigned count);
      int unsigned stop_at;
      int unsigned plen;
      logic [9:0]  ml;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(3))
                  0: send_byte(8'($urandom));
                  1: send_read();
                  2: send_take(10'($urandom));
                  default: send_item(ACT_UNUSED, 8'($urandom), 9'($urandom), 10'($urandom));
               endcase
            end
         end else begin
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
            if ($urandom_range(99) < 6)
               send_marker(start_mk, $urandom_range(1, 2));
            else
               send_marker(start_mk, 3);
            if ($urandom_range(99) < 3)
               plen = $urandom_range(200, 520);
            else if ($urandom_range(99) < 10)
               plen = $urandom_range(13, 60);
            else
               plen = $urandom_range(0, 12);
            repeat (plen) send_byte(8'($urandom));
            if ($urandom_range(99) < 8)
               send_marker(end_mk, $urandom_range(1, 2));
            else
               send_marker(end_mk, 3);
            repeat ($urandom_range(0, 3)) send_read();
            if ($urandom_range(99) < 85) begin
               case ($urandom_range(3))
                  0: ml = 10'($urandom);
                  1: ml = 10'(frame_len);
                  2: ml = (frame_len == 0) ? 10'd0 : 10'(frame_len - 1);
                  default: ml = 10'($urandom_range(512, 1023));
               endcase
               send_take(ml);
            end
         end
      end
   endtask

   initial begin
      logic [23:0] s;
      logic [23:0] e;
      logic [7:0]  rep;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_default_frame();
      test_mismatch_and_empty_frame();
      test_long_frames();
      for (int p = 0; p < 6; p++) begin
         if (p < 2) begin
            send_idle_pct = 13;
            recv_idle_pct = 82;
         end else if (p < 4) begin
            send_idle_pct = 82;
            recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         rep = 8'($urandom);
         case (p)
            0: begin
               s = mfbr_pkg::START_RESET;
               e = mfbr_pkg::END_RESET;
            end
            1: begin
               s = 24'h000000;
               e = 24'hFFFFFF;
            end
            3: begin
               s = 24'hFFFFFF;
               e = 24'h000000;
            end
            4: begin
               s = {3{rep}};
               e = 24'($urandom);
            end
            default: begin
               s = 24'($urandom);
               e = 24'($urandom);
            end
         endcase
         change_markers(s, e);
         test_random_frames(110);
      end
      wait_for_results();
      repeat (8) @(posedge clock);
      if (expected_status_q.size() != 0) begin
         $display("%0t: %0d transactions never arrived", $time, expected_status_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
